// ===== rtl/core/p2gh_pkg.sv =====
// ----------------------------------------------------------------------------
// p2gh_pkg: shared types and constants of the pixel-to-ground mapping core
// Holds request and result structs, widths and register indexes.
// ----------------------------------------------------------------------------
package p2gh_pkg;

    localparam int PIXEL_BITS = 12;
    localparam int COEF_BITS  = 21;
    localparam int ROW_BITS   = 63;
    localparam int ACC_BITS   = COEF_BITS + PIXEL_BITS + 2;
    localparam int MAG_BITS   = ACC_BITS;
    localparam int NUM_BITS   = MAG_BITS + 8;
    localparam int Q_BITS     = 25;
    localparam int OUT_BITS   = 24;
    localparam int FLOOR_BITS = 34;
    localparam int IDX_BITS   = 3;
    localparam int DATA_BITS  = 63;

    localparam logic [IDX_BITS-1:0] REG_ROW0    = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_ROW1    = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_ROW2    = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_MIN_FWD = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_MAX_FWD = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_W_FLOOR = 3'd5;

    typedef struct packed {
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
        logic        list_end;
    } t_in_req;

    typedef struct packed {
        logic signed [23:0] ground_x;
        logic signed [23:0] ground_y;
        logic               kept;
        logic               run_end;
    } t_out_res;

    // Per-item travelling state through the divider chain
    typedef struct packed {
        logic                vld;
        logic [NUM_BITS-1:0] rem_x;
        logic [NUM_BITS-1:0] rem_y;
        logic [Q_BITS-1:0]   q_x;
        logic [Q_BITS-1:0]   q_y;
        logic [MAG_BITS-1:0] den;
        logic                neg_x;
        logic                neg_y;
        logic                ok;
        logic                last;
    } t_div_tok;

endpackage

// ===== rtl/core/p2gh_div_cell.sv =====
// ----------------------------------------------------------------------------
// p2gh_div_cell: one restoring-division step for both quotients
// Registers one quotient bit of x and y per cycle while i_en is high and passes the token on.
// ----------------------------------------------------------------------------
module p2gh_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [4:0]          i_bit,
    input  p2gh_pkg::t_div_tok  i_tok,
    output p2gh_pkg::t_div_tok  o_tok
);

    p2gh_pkg::t_div_tok r_tok;
    p2gh_pkg::t_div_tok n_tok;
    logic [p2gh_pkg::NUM_BITS+p2gh_pkg::Q_BITS-1:0] w_dsh;

    always_comb begin
        n_tok = i_tok;
        w_dsh = {{p2gh_pkg::Q_BITS{1'b0}}, {8'd0}, i_tok.den} << i_bit;
        if ({{p2gh_pkg::Q_BITS{1'b0}}, i_tok.rem_x} >= w_dsh) begin
            n_tok.rem_x = i_tok.rem_x - w_dsh[p2gh_pkg::NUM_BITS-1:0];
            n_tok.q_x[i_bit] = 1'b1;
        end
        if ({{p2gh_pkg::Q_BITS{1'b0}}, i_tok.rem_y} >= w_dsh) begin
            n_tok.rem_y = i_tok.rem_y - w_dsh[p2gh_pkg::NUM_BITS-1:0];
            n_tok.q_y[i_bit] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/core/pixel_to_ground_homography_core.sv =====
// ----------------------------------------------------------------------------
// pixel_to_ground_homography_core: pixel to ground-plane mapping
// Maps pixel requests through a 3x3 inverse homography to Q15.8 metres.
// ----------------------------------------------------------------------------
// One request per clock, one result per request. The pipeline holds two
// multiply-accumulate stages, one sign stage, then a chain of 25 division
// cells, one quotient bit each, then the range check into the output
// register. The whole pipeline stalls only while the output is not taken.
module pixel_to_ground_homography_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  p2gh_pkg::t_in_req                   i_req,
    output logic                                o_valid,
    input  logic                                i_ready,
    output p2gh_pkg::t_out_res                  o_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [p2gh_pkg::IDX_BITS-1:0]       i_cfg_index,
    input  logic [p2gh_pkg::DATA_BITS-1:0]      i_cfg_data
);

    localparam int NC = p2gh_pkg::Q_BITS;
    localparam int CB = p2gh_pkg::COEF_BITS;
    localparam int AB = p2gh_pkg::ACC_BITS;
    localparam int MB = p2gh_pkg::MAG_BITS;
    localparam int NB = p2gh_pkg::NUM_BITS;

    logic [p2gh_pkg::ROW_BITS-1:0] r_row0, r_row1, r_row2;
    logic signed [23:0]            r_min_fwd, r_max_fwd;
    logic [p2gh_pkg::FLOOR_BITS-1:0] r_w_floor;

    logic w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0    <= '0;
            r_row1    <= '0;
            r_row2    <= '0;
            r_min_fwd <= 24'sd256;
            r_max_fwd <= 24'sd12800;
            r_w_floor <= 34'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                p2gh_pkg::REG_ROW0:    r_row0 <= i_cfg_data;
                p2gh_pkg::REG_ROW1:    r_row1 <= i_cfg_data;
                p2gh_pkg::REG_ROW2:    r_row2 <= i_cfg_data;
                p2gh_pkg::REG_MIN_FWD: r_min_fwd <= i_cfg_data[23:0];
                p2gh_pkg::REG_MAX_FWD: r_max_fwd <= i_cfg_data[23:0];
                p2gh_pkg::REG_W_FLOOR: r_w_floor <= i_cfg_data[33:0];
                default: ;
            endcase
        end
    end

    // Stage 1: products
    logic r_s1_vld, r_s1_last;
    logic signed [AB-1:0] r_px[3], r_py[3], r_pc[3];
    logic signed [AB-1:0] n_px[3], n_py[3], n_pc[3];
    logic [p2gh_pkg::ROW_BITS-1:0] w_rows[3];
    assign w_rows[0] = r_row0;
    assign w_rows[1] = r_row1;
    assign w_rows[2] = r_row2;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_px[k] = AB'($signed(w_rows[k][CB-1:0]) *
                      $signed({1'b0, i_req.pixel_col[p2gh_pkg::PIXEL_BITS-1:0]}));
            n_py[k] = AB'($signed(w_rows[k][2*CB-1:CB]) *
                      $signed({1'b0, i_req.pixel_row[p2gh_pkg::PIXEL_BITS-1:0]}));
            n_pc[k] = AB'($signed(w_rows[k][3*CB-1:2*CB]));
        end
    end

    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_valid;
        end
        if (w_en) begin
            r_s1_last <= i_req.list_end;
            for (int k = 0; k < 3; k++) begin
                r_px[k] <= n_px[k];
                r_py[k] <= n_py[k];
                r_pc[k] <= n_pc[k];
            end
        end
    end

    // Stage 2: sums
    logic r_s2_vld, r_s2_last;
    logic signed [AB-1:0] r_acc[3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
        if (w_en) begin
            r_s2_last <= r_s1_last;
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= r_px[k] + r_py[k] + r_pc[k];
            end
        end
    end

    // Stage 3: magnitudes, signs and floor test into the first token
    p2gh_pkg::t_div_tok r_tok0, n_tok0;
    logic [MB-1:0] w_mx, w_my, w_mw;
    always_comb begin
        w_mx = r_acc[0][AB-1] ? MB'(-r_acc[0]) : MB'(r_acc[0]);
        w_my = r_acc[1][AB-1] ? MB'(-r_acc[1]) : MB'(r_acc[1]);
        w_mw = r_acc[2][AB-1] ? MB'(-r_acc[2]) : MB'(r_acc[2]);
        n_tok0.vld   = r_s2_vld;
        n_tok0.rem_x = {w_mx, 8'd0};
        n_tok0.rem_y = {w_my, 8'd0};
        n_tok0.q_x   = '0;
        n_tok0.q_y   = '0;
        n_tok0.den   = w_mw;
        n_tok0.neg_x = r_acc[0][AB-1] ^ r_acc[2][AB-1];
        n_tok0.neg_y = r_acc[1][AB-1] ^ r_acc[2][AB-1];
        n_tok0.ok    = (w_mw != '0) &&
                       (w_mw >= {{(MB-p2gh_pkg::FLOOR_BITS){1'b0}}, r_w_floor});
        n_tok0.last  = r_s2_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0.vld <= 1'b0;
        end else if (w_en) begin
            r_tok0 <= n_tok0;
        end
    end

    // Division chain; quotients beyond 25 bits saturate below
    p2gh_pkg::t_div_tok w_tok[NC+1];
    logic w_ovx[NC+1], w_ovy[NC+1];
    assign w_tok[0] = r_tok0;

    genvar g;
    generate
        for (g = 0; g < NC; g++) begin : g_cell
            p2gh_div_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (w_en),
                .i_bit  (5'(NC-1-g)),
                .i_tok  (w_tok[g]),
                .o_tok  (w_tok[g+1])
            );
        end
    endgenerate

    // Overflow: quotient >= 2^25 iff rem >= den << 25, checked on entry
    logic [NB+NC-1:0] w_big;
    logic r_ovx[NC], r_ovy[NC];
    assign w_big = {{NC{1'b0}}, 8'd0, r_tok0.den} << NC;
    assign w_ovx[0] = {{NC{1'b0}}, r_tok0.rem_x} >= w_big;
    assign w_ovy[0] = {{NC{1'b0}}, r_tok0.rem_y} >= w_big;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NC; k++) begin
                r_ovx[k] <= w_ovx[k];
                r_ovy[k] <= w_ovy[k];
            end
        end
    end
    generate
        for (g = 1; g <= NC; g++) begin : g_ov
            assign w_ovx[g] = r_ovx[g-1];
            assign w_ovy[g] = r_ovy[g-1];
        end
    endgenerate

    // Final: sign, saturate, range check
    p2gh_pkg::t_div_tok w_last;
    logic signed [23:0] w_gx, w_gy;
    logic [NC-1:0] w_qx, w_qy;
    assign w_last = w_tok[NC];

    function automatic logic signed [23:0] sat_q(input logic [NC-1:0] q,
                                                 input logic ov, input logic neg);
        logic signed [23:0] r;
        if (neg) begin
            if (ov || q > NC'(8388608)) r = -24'sd8388608;
            else r = 24'(-$signed({1'b0, q}));
        end else begin
            if (ov || q > NC'(8388607)) r = 24'sd8388607;
            else r = q[23:0];
        end
        return r;
    endfunction

    assign w_qx = w_last.q_x;
    assign w_qy = w_last.q_y;
    always_comb begin
        if (w_last.ok) begin
            w_gx = sat_q(w_qx, w_ovx[NC], w_last.neg_x);
            w_gy = sat_q(w_qy, w_ovy[NC], w_last.neg_y);
        end else begin
            w_gx = '0;
            w_gy = '0;
        end
    end

    logic r_out_vld;
    p2gh_pkg::t_out_res r_out;
    assign w_en = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_last.vld;
        end
        if (w_en) begin
            r_out.ground_x <= w_gx;
            r_out.ground_y <= w_gy;
            r_out.kept     <= w_last.ok && (w_gx >= r_min_fwd) && (w_gx <= r_max_fwd);
            r_out.run_end  <= w_last.last;
        end
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_res)))
        else $error("result changed under stall");
    a_kept_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.kept) |-> (o_res.ground_x >= r_min_fwd))
        else $error("kept result below range");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid) |-> o_ready)
        else $error("stalled with empty output");

endmodule

// ===== bench/tb_pixel_to_ground_homography_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_to_ground_homography_core: self-checking bench of the mapping core
// Drives pixel requests through directed and random matrix settings, with
// idle and stall patterns on both channels. Each result is compared against
// a bit-exact software model of the homography, divide and range check.
// ----------------------------------------------------------------------------
module tb_pixel_to_ground_homography_core;

    localparam int PIPE_WAIT  = 40;
    localparam int IDLE_LIMIT = 5000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 150;

    localparam logic [p2gh_pkg::IDX_BITS-1:0] REG_SPARE_A = 3'd6;
    localparam logic [p2gh_pkg::IDX_BITS-1:0] REG_SPARE_B = 3'd7;

    typedef struct {
        int          setting;
        logic [11:0] col;
        logic [11:0] row;
        logic        last;
        bit          typed;
    } t_dir_row;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_ready;
    p2gh_pkg::t_in_req                   i_req;
    logic                                o_valid;
    logic                                i_ready;
    p2gh_pkg::t_out_res                  o_res;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [p2gh_pkg::IDX_BITS-1:0]       i_cfg_index;
    logic [p2gh_pkg::DATA_BITS-1:0]      i_cfg_data;

    logic [p2gh_pkg::ROW_BITS-1:0]       row_x;
    logic [p2gh_pkg::ROW_BITS-1:0]       row_y;
    logic [p2gh_pkg::ROW_BITS-1:0]       row_w;
    logic [23:0]                         fwd_min;
    logic [23:0]                         fwd_max;
    logic [p2gh_pkg::FLOOR_BITS-1:0]     weight_floor;

    p2gh_pkg::t_out_res                  ground_q[$];
    int                                  fail_cnt;
    int                                  idle_cnt;
    int                                  stall_pct;
    int                                  gap_pct;
    t_dir_row                            dir_tab[19];

    pixel_to_ground_homography_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [p2gh_pkg::ROW_BITS-1:0] pack_row(int c_col, int c_row,
                                                               int c_k);
        logic [20:0] a;
        logic [20:0] b;
        logic [20:0] c;
        a = c_col[20:0];
        b = c_row[20:0];
        c = c_k[20:0];
        return {c, b, a};
    endfunction

    function automatic longint row_acc(logic [p2gh_pkg::ROW_BITS-1:0] r, longint u,
                                       longint v);
        longint a;
        longint b;
        longint c;
        a = longint'($signed(r[20:0]));
        b = longint'($signed(r[41:21]));
        c = longint'($signed(r[62:42]));
        return a * u + b * v + c;
    endfunction

    function automatic logic [23:0] sat_ratio(longint num, longint den);
        longint q;
        q = (num * 256) / den;
        if (q > 64'sd8388607) q = 64'sd8388607;
        if (q < -64'sd8388608) q = -64'sd8388608;
        return q[23:0];
    endfunction

    function automatic p2gh_pkg::t_out_res map_pixel(p2gh_pkg::t_in_req r);
        longint             ax;
        longint             ay;
        longint             aw;
        longint             gx;
        p2gh_pkg::t_out_res o;
        ax = row_acc(row_x, longint'(r.pixel_col), longint'(r.pixel_row));
        ay = row_acc(row_y, longint'(r.pixel_col), longint'(r.pixel_row));
        aw = row_acc(row_w, longint'(r.pixel_col), longint'(r.pixel_row));
        o = '0;
        o.run_end = r.list_end;
        if (aw != 0 && (aw < 0 ? -aw : aw) >= longint'(weight_floor)) begin
            o.ground_x = sat_ratio(ax, aw);
            o.ground_y = sat_ratio(ay, aw);
            gx = longint'(o.ground_x);
            o.kept = (gx >= longint'($signed(fwd_min)) && gx <= longint'($signed(fwd_max)));
        end
        return o;
    endfunction

    task automatic write_reg(logic [p2gh_pkg::IDX_BITS-1:0] idx,
                             logic [p2gh_pkg::DATA_BITS-1:0] data);
        bit f;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            f = o_cfg_ready;
            if (f) begin
                case (idx)
                    p2gh_pkg::REG_ROW0:    row_x = data;
                    p2gh_pkg::REG_ROW1:    row_y = data;
                    p2gh_pkg::REG_ROW2:    row_w = data;
                    p2gh_pkg::REG_MIN_FWD: fwd_min = data[23:0];
                    p2gh_pkg::REG_MAX_FWD: fwd_max = data[23:0];
                    p2gh_pkg::REG_W_FLOOR: weight_floor = data[p2gh_pkg::FLOOR_BITS-1:0];
                    default: ;
                endcase
            end
            @(posedge i_clk);
        end while (!f);
    endtask

    task automatic push_pixel(p2gh_pkg::t_in_req r, bit typed);
        bit                 f;
        p2gh_pkg::t_out_res e;
        i_valid <= 1'b1;
        i_req   <= r;
        do begin
            @(negedge i_clk);
            f = o_ready;
            if (f) begin
                e = typed ? p2gh_pkg::t_out_res'({48'd0, 1'b0, r.list_end}) : map_pixel(r);
                ground_q.push_back(e);
            end
            @(posedge i_clk);
        end while (!f);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (ground_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_WAIT) @(posedge i_clk);
    endtask

    task automatic load_setting(int sel);
        logic [p2gh_pkg::DATA_BITS-1:0] r0, r1, r2, lo, hi, fl;
        r0 = pack_row(40, 300, 262144);
        r1 = pack_row(300, -5, -600000);
        r2 = pack_row(0, 64, 65536);
        lo = 63'd256;
        hi = 63'd12800;
        fl = 63'd1;
        case (sel)
            2: begin
                r2 = '0;
                fl = '0;
            end
            3: fl = 63'h3_FFFF_FFFF;
            4: begin
                lo = 63'h7F_FFFF;
                hi = 63'h80_0000;
            end
            5: begin
                r0 = pack_row(-1048576, -1048576, -1048576);
                r1 = pack_row(1048575, 1048575, 1048575);
                r2 = pack_row(0, 0, 1);
                lo = 63'h80_0000;
                hi = 63'h7F_FFFF;
                fl = '0;
                write_reg(REG_SPARE_A, 63'({$urandom, $urandom}));
                write_reg(REG_SPARE_B, '1);
            end
            6: begin
                r2 = pack_row($urandom_range(16) - 8, $urandom_range(64),
                              16384 + $urandom_range(16384));
                r0 = pack_row($urandom_range(128) - 64, $urandom_range(1024) - 512,
                              $urandom_range(1048575));
                r1 = pack_row($urandom_range(512) - 256, $urandom_range(128) - 64,
                              $urandom_range(2097151) - 1048576);
                lo = 63'($urandom_range(2000));
                hi = 63'(5000 + $urandom_range(11000));
                fl = 63'($urandom_range(20000));
            end
            7: begin
                r0 = 63'({$urandom, $urandom});
                r1 = 63'({$urandom, $urandom});
                r2 = 63'({$urandom, $urandom});
                lo = 63'($urandom);
                hi = 63'($urandom);
                fl = {29'd0, 2'($urandom), $urandom} >> $urandom_range(33);
            end
            default: ;
        endcase
        write_reg(p2gh_pkg::REG_ROW0, r0);
        write_reg(p2gh_pkg::REG_ROW1, r1);
        write_reg(p2gh_pkg::REG_ROW2, r2);
        write_reg(p2gh_pkg::REG_MIN_FWD, lo);
        write_reg(p2gh_pkg::REG_MAX_FWD, hi);
        write_reg(p2gh_pkg::REG_W_FLOOR, fl);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(negedge i_clk) begin
        p2gh_pkg::t_out_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (ground_q.size() == 0) begin
                $error("result with nothing outstanding: %h", o_res);
                fail_cnt++;
            end else begin
                e = ground_q.pop_front();
                if (o_res.ground_x !== e.ground_x) begin
                    $error("ground_x exp %h got %h", e.ground_x, o_res.ground_x);
                    fail_cnt++;
                end
                if (o_res.ground_y !== e.ground_y) begin
                    $error("ground_y exp %h got %h", e.ground_y, o_res.ground_y);
                    fail_cnt++;
                end
                if (o_res.kept !== e.kept) begin
                    $error("kept exp %b got %b", e.kept, o_res.kept);
                    fail_cnt++;
                end
                if (o_res.run_end !== e.run_end) begin
                    $error("run_end exp %b got %b", e.run_end, o_res.run_end);
                    fail_cnt++;
                end
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n) begin
            idle_cnt = 0;
        end else begin
            idle_cnt++;
        end
        if (idle_cnt > IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        p2gh_pkg::t_in_req r;
        int                sel;
        int                mode;
        fail_cnt     = 0;
        idle_cnt     = 0;
        stall_pct    = 0;
        gap_pct      = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_req        = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        row_x        = '0;
        row_y        = '0;
        row_w        = '0;
        fwd_min      = 24'd256;
        fwd_max      = 24'd12800;
        weight_floor = 34'd1;
        dir_tab = '{
            '{0, 12'd0,    12'd0,    1'b0, 1'b1},
            '{0, 12'd4095, 12'd4095, 1'b1, 1'b1},
            '{0, 12'd4095, 12'd0,    1'b0, 1'b1},
            '{0, 12'd0,    12'd4095, 1'b1, 1'b1},
            '{1, 12'd0,    12'd0,    1'b0, 1'b0},
            '{1, 12'd4095, 12'd4095, 1'b0, 1'b0},
            '{1, 12'd640,  12'd300,  1'b0, 1'b0},
            '{1, 12'd1920, 12'd1080, 1'b1, 1'b0},
            '{2, 12'd1234, 12'd567,  1'b0, 1'b1},
            '{2, 12'd4095, 12'd4095, 1'b1, 1'b1},
            '{3, 12'd100,  12'd2000, 1'b0, 1'b1},
            '{3, 12'd4095, 12'd4095, 1'b1, 1'b1},
            '{4, 12'd640,  12'd300,  1'b0, 1'b0},
            '{4, 12'd0,    12'd4095, 1'b1, 1'b0},
            '{5, 12'd0,    12'd0,    1'b0, 1'b0},
            '{5, 12'd4095, 12'd4095, 1'b0, 1'b0},
            '{5, 12'd4095, 12'd0,    1'b0, 1'b0},
            '{5, 12'd0,    12'd4095, 1'b1, 1'b0},
            '{5, 12'd2048, 12'd2048, 1'b1, 1'b0}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sel = 0;
        foreach (dir_tab[k]) begin
            if (dir_tab[k].setting != sel) begin
                drain();
                sel = dir_tab[k].setting;
                load_setting(sel);
            end
            r.pixel_col = dir_tab[k].col;
            r.pixel_row = dir_tab[k].row;
            r.list_end  = dir_tab[k].last;
            push_pixel(r, dir_tab[k].typed);
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            load_setting(p == 5 ? 5 : (p % 3 == 2 ? 7 : 6));
            mode = p % 4;
            gap_pct   = (mode == 1) ? 86 : (mode == 3) ? 25 : 0;
            stall_pct = (mode == 2) ? 86 : (mode == 3) ? 25 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                while ($urandom_range(99) < gap_pct) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                end
                r.pixel_col = 12'($urandom);
                r.pixel_row = 12'($urandom);
                r.list_end  = ($urandom_range(7) == 0);
                push_pixel(r, 1'b0);
            end
        end
        stall_pct = 0;
        drain();

        if (fail_cnt == 0 && ground_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
